>>> rtl/core/prtb_pkg.sv
`timescale 1ns / 1ps
package prtb_pkg;

  localparam int RATE_W = 40;
  localparam int MTU_W = 16;
  localparam int TIME_W = 64;
  localparam int TOK_W = 34;
  localparam int CAP_W = 32;
  localparam int REM_W = 20;
  localparam int CREDIT_W = 33;
  localparam int CNT_W = 7;

  localparam logic [RATE_W-1:0] CREDIT_DIVISOR = RATE_W'(20);
  localparam logic [RATE_W-1:0] USEC_PER_SEC = RATE_W'(1000000);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RATE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TIME_W - 1);
  localparam logic signed [TOK_W-1:0] TOKENS_MIN = -(TOK_W'(64'sd4294967296));
  localparam logic [0:0] REG_PACING_RATE = 1'b0;
  localparam logic [0:0] REG_PATH_MTU = 1'b1;
  localparam logic [MTU_W-1:0] MTU_RESET = MTU_W'(1200);

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_TRY = 3'd1,
    CMD_SCHEDULED = 3'd2,
    CMD_PEEK = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_MTU_UPDATE = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REFILL,
    S_RMUL1,
    S_RDIV1,
    S_RCMP,
    S_RMUL2,
    S_RDIV2,
    S_RADD,
    S_TRY,
    S_TMUL,
    S_TDIV,
    S_TFIN,
    S_CDIV,
    S_CFIN,
    S_DONE
  } state_t;

  function automatic logic [MTU_W-1:0] pkt_size(input logic [MTU_W-1:0] ws,
                                                  input logic [MTU_W-1:0] mtu);
    logic [MTU_W-1:0] m;
    m = (mtu == '0) ? MTU_W'(1) : mtu;
    return (ws == '0) ? m : ws;
  endfunction

endpackage

>>> rtl/core/prtb_if.sv
`timescale 1ns / 1ps
interface prtb_in_if;
  logic valid;
  logic ready;
  logic [2:0] command;
  logic [63:0] now_usec;
  logic [15:0] wire_size;
  modport source (output valid, command, now_usec, wire_size, input ready);
  modport sink (input valid, command, now_usec, wire_size, output ready);
endinterface

interface prtb_out_if;
  logic valid;
  logic ready;
  logic allowed;
  logic delayed;
  logic [63:0] next_send_usec;
  logic signed [32:0] credit;
  modport source (output valid, allowed, delayed, next_send_usec, credit, input ready);
  modport sink (input valid, allowed, delayed, next_send_usec, credit, output ready);
endinterface

>>> rtl/core/pacing_rate_token_bucket.sv
`timescale 1ns / 1ps
// byte token bucket pacing a packet sender
// cmd: one item per command (tick, try, scheduled, peek, restart, mtu update)
//   with now_usec and wire_size; res: one item per command with the verdict,
//   the delayed flag, the earliest send time and the signed token count
// cfg: plain write port, index 0 pacing rate (40 bits), index 1 path mtu
// with a nonzero rate, restart and mtu update recompute the capacity
//   (a divide by 20), a tick or try refills the bucket, and a try that
//   misses also works out the earliest send time
// the work is done by one shared bit-serial unit: a shift-add multiplier of
//   40 steps and a restoring divider of 64 steps, one bit per cycle
// one item is worked on at a time; the next command is taken once the result
//   sits in the output register, so a stalled receiver holds at most one
//   finished item plus the one in work
// reset clears the bucket to zero, the rate to zero (limiter off) and the
//   path mtu to 1200
module pacing_rate_token_bucket (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [prtb_pkg::RATE_W-1:0] cfg_data,
  prtb_in_if.sink cmd_ch,
  prtb_out_if.source res_ch
);
  import prtb_pkg::*;

  logic [RATE_W-1:0] pacing_rate;
  logic [MTU_W-1:0] link_mtu;

  logic signed [TOK_W-1:0] tokens;
  logic [CAP_W-1:0] capacity;
  logic [REM_W-1:0] byte_remainder;
  logic [TIME_W-1:0] last_refill_time;
  logic [TIME_W-1:0] next_sched_time;
  logic delayed_flag;
  logic [TIME_W-1:0] current_time;

  state_t state, state_next;
  logic [2:0] cmd;
  logic [MTU_W-1:0] ws;
  logic allowed;
  logic [TIME_W-1:0] elapsed;

  logic [TIME_W-1:0] acc, mul_a;
  logic [RATE_W-1:0] mul_b;
  logic [TIME_W-1:0] dnum;
  logic [RATE_W-1:0] dden, drem;
  logic [CNT_W-1:0] cnt;

  logic in_take, out_load, rate_on, refill_skip, mul_end, div_end;
  logic [TIME_W-1:0] acc_next;
  logic [RATE_W:0] trial;
  logic trial_ge;
  logic [TIME_W-1:0] delay;
  logic [MTU_W-1:0] ps_in, ps;
  logic [TOK_W-1:0] needed, deficit;
  logic signed [TOK_W-1:0] tok_sub;
  logic [MTU_W-1:0] eff_mtu;
  logic [21:0] mtu_credit;
  logic [35:0] cap_t, cap_c;
  logic [CAP_W-1:0] cap_new;

  assign rate_on = (pacing_rate != '0);
  assign eff_mtu = (link_mtu == '0) ? MTU_W'(1) : link_mtu;
  assign ps_in = pkt_size(cmd_ch.wire_size, link_mtu);
  assign ps = pkt_size(ws, link_mtu);
  assign needed = {2'b00, capacity} - tokens;
  assign deficit = {{(TOK_W-MTU_W){1'b0}}, ps} - tokens;
  assign tok_sub = tokens - $signed({{(TOK_W-MTU_W){1'b0}}, ps_in});
  assign acc_next = mul_b[0] ? acc + mul_a : acc;
  assign trial = {drem, dnum[TIME_W-1]};
  assign trial_ge = trial >= {1'b0, dden};
  assign delay = dnum + TIME_W'(drem != '0);
  assign mul_end = (cnt == MUL_LAST);
  assign div_end = (cnt == DIV_LAST);
  assign refill_skip = !rate_on || (current_time <= last_refill_time);

  // capacity: min(rate/20, 48 mtu), at least one mtu, at most 32 bits
  assign mtu_credit = {1'b0, eff_mtu, 5'b0} + {2'b0, eff_mtu, 4'b0};
  assign cap_t = dnum[35:0];
  always_comb begin
    cap_c = (cap_t < {14'b0, mtu_credit}) ? cap_t : {14'b0, mtu_credit};
    if (cap_c < {20'b0, eff_mtu}) cap_c = {20'b0, eff_mtu};
    cap_new = (cap_c[35:32] != '0) ? '1 : cap_c[31:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_ch.valid) begin
          case (cmd_ch.command)
            CMD_TICK: state_next = S_REFILL;
            CMD_TRY: state_next = rate_on ? S_REFILL : S_DONE;
            CMD_RESTART, CMD_MTU_UPDATE: state_next = rate_on ? S_CDIV : S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_REFILL: begin
        if (refill_skip || tokens >= $signed({2'b00, capacity}))
          state_next = (cmd == CMD_TRY) ? S_TRY : S_DONE;
        else state_next = S_RMUL1;
      end
      S_RMUL1: if (mul_end) state_next = S_RDIV1;
      S_RDIV1: if (div_end) state_next = S_RCMP;
      S_RCMP: begin
        if (elapsed >= delay) state_next = (cmd == CMD_TRY) ? S_TRY : S_DONE;
        else state_next = S_RMUL2;
      end
      S_RMUL2: if (mul_end) state_next = S_RDIV2;
      S_RDIV2: if (div_end) state_next = S_RADD;
      S_RADD: state_next = (cmd == CMD_TRY) ? S_TRY : S_DONE;
      S_TRY: state_next = (tokens >= $signed({{(TOK_W-MTU_W){1'b0}}, ps})) ? S_DONE : S_TMUL;
      S_TMUL: if (mul_end) state_next = S_TDIV;
      S_TDIV: if (div_end) state_next = S_TFIN;
      S_TFIN: state_next = S_DONE;
      S_CDIV: if (div_end) state_next = S_CFIN;
      S_CFIN: state_next = S_DONE;
      S_DONE: if (!res_ch.valid || res_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_take = 1'b0;
    out_load = 1'b0;
    cmd_ch.ready = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ch.ready = 1'b1;
        in_take = cmd_ch.valid;
      end
      S_DONE: out_load = !res_ch.valid || res_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pacing_rate <= '0;
      link_mtu <= MTU_RESET;
      tokens <= '0;
      capacity <= '0;
      byte_remainder <= '0;
      last_refill_time <= '0;
      next_sched_time <= '0;
      delayed_flag <= 1'b0;
      current_time <= '0;
      res_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_PACING_RATE: pacing_rate <= cfg_data;
          REG_PATH_MTU: link_mtu <= cfg_data[MTU_W-1:0];
          default: ;
        endcase
      end
      if (out_load) res_ch.valid <= 1'b1;
      else if (res_ch.ready) res_ch.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_take) begin
            case (cmd_ch.command)
              CMD_TICK: current_time <= cmd_ch.now_usec;
              CMD_SCHEDULED: begin
                if (rate_on) tokens <= (tok_sub < TOKENS_MIN) ? TOKENS_MIN : tok_sub;
              end
              CMD_RESTART: begin
                if (!rate_on) begin
                  byte_remainder <= '0;
                  last_refill_time <= current_time;
                  next_sched_time <= '0;
                  delayed_flag <= 1'b0;
                  capacity <= '0;
                  tokens <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_REFILL: begin
          if (!refill_skip) begin
            last_refill_time <= current_time;
            if (tokens >= $signed({2'b00, capacity})) begin
              tokens <= $signed({2'b00, capacity});
              byte_remainder <= '0;
            end
          end
        end
        S_RCMP: begin
          if (elapsed >= delay) begin
            tokens <= $signed({2'b00, capacity});
            byte_remainder <= '0;
          end
        end
        S_RADD: begin
          tokens <= tokens + $signed(dnum[TOK_W-1:0]);
          byte_remainder <= drem[REM_W-1:0];
        end
        S_TRY: begin
          if (tokens >= $signed({{(TOK_W-MTU_W){1'b0}}, ps})) begin
            delayed_flag <= 1'b0;
            next_sched_time <= '0;
          end
        end
        S_TFIN: begin
          // saturate the send time instead of wrapping
          next_sched_time <= (delay > ~current_time) ? '1 : current_time + delay;
          delayed_flag <= 1'b1;
        end
        S_CFIN: begin
          capacity <= cap_new;
          if (cmd == CMD_RESTART) begin
            tokens <= $signed({2'b00, cap_new});
            byte_remainder <= '0;
            last_refill_time <= current_time;
            next_sched_time <= '0;
            delayed_flag <= 1'b0;
          end else if (tokens > $signed({2'b00, cap_new})) begin
            tokens <= $signed({2'b00, cap_new});
          end
        end
        default: ;
      endcase
    end
  end

  // serial datapath, item fields and result payload
  always_ff @(posedge clk) begin
    cnt <= cnt + CNT_W'(1);
    if (in_take) begin
      cmd <= cmd_ch.command;
      ws <= cmd_ch.wire_size;
      case (cmd_ch.command)
        CMD_TRY: allowed <= !rate_on;
        CMD_PEEK: allowed <= !rate_on || tokens >= $signed({{(TOK_W-MTU_W){1'b0}}, ps_in});
        default: allowed <= 1'b0;
      endcase
      dnum <= {{(TIME_W-RATE_W){1'b0}}, pacing_rate};
      dden <= CREDIT_DIVISOR;
      drem <= '0;
      cnt <= '0;
    end
    case (state)
      S_REFILL: begin
        elapsed <= current_time - last_refill_time;
        acc <= '0;
        mul_a <= {{(TIME_W-TOK_W){1'b0}}, needed};
        mul_b <= USEC_PER_SEC;
        cnt <= '0;
      end
      S_RCMP: begin
        acc <= '0;
        mul_a <= elapsed;
        mul_b <= pacing_rate;
        cnt <= '0;
      end
      S_TRY: begin
        allowed <= tokens >= $signed({{(TOK_W-MTU_W){1'b0}}, ps});
        acc <= '0;
        mul_a <= {{(TIME_W-TOK_W){1'b0}}, deficit};
        mul_b <= USEC_PER_SEC;
        cnt <= '0;
      end
      S_RMUL1, S_RMUL2, S_TMUL: begin
        acc <= acc_next;
        mul_a <= {mul_a[TIME_W-2:0], 1'b0};
        mul_b <= {1'b0, mul_b[RATE_W-1:1]};
        if (mul_end) begin
          // load the divider straight from the last partial sum
          cnt <= '0;
          drem <= '0;
          if (state == S_RMUL2) begin
            dnum <= acc_next + {{(TIME_W-REM_W){1'b0}}, byte_remainder};
            dden <= USEC_PER_SEC;
          end else begin
            dnum <= acc_next - {{(TIME_W-REM_W){1'b0}}, byte_remainder};
            dden <= pacing_rate;
          end
        end
      end
      S_RDIV1, S_RDIV2, S_TDIV, S_CDIV: begin
        drem <= trial_ge ? trial[RATE_W-1:0] - dden : trial[RATE_W-1:0];
        dnum <= {dnum[TIME_W-2:0], trial_ge};
      end
      default: ;
    endcase
    if (out_load) begin
      res_ch.allowed <= allowed;
      res_ch.delayed <= delayed_flag;
      res_ch.next_send_usec <= next_sched_time;
      res_ch.credit <= tokens[CREDIT_W-1:0];
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    byte_remainder < USEC_PER_SEC[REM_W-1:0])
    else $error("byte remainder out of range");

  a_tok_cap: assert property (@(posedge clk) disable iff (rst)
    tokens <= $signed({2'b00, capacity}))
    else $error("tokens above capacity");

  a_tok_min: assert property (@(posedge clk) disable iff (rst)
    tokens >= TOKENS_MIN)
    else $error("tokens below floor");

  a_delay_pair: assert property (@(posedge clk) disable iff (rst)
    !delayed_flag |-> next_sched_time == '0)
    else $error("send time set without delay");

endmodule
